>>> sv/acm_pkg.sv
package acm_pkg;

    // Port widths fixed by the item format
    localparam int ADDR_BITS    = 7;
    localparam int CODE_BITS    = 7;
    localparam int IO_WORD_BITS = 32;

    // Defaults for the top-level parameters
    localparam int MEM_CELLS_DEF = 128;
    localparam int WORD_BITS_DEF = 32;

    // Request kinds
    localparam logic OP_EXEC  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // Instruction codes
    localparam logic [CODE_BITS-1:0] CODE_ADD  = 7'h30;
    localparam logic [CODE_BITS-1:0] CODE_SUB  = 7'h31;
    localparam logic [CODE_BITS-1:0] CODE_DIV  = 7'h32;
    localparam logic [CODE_BITS-1:0] CODE_MUL  = 7'h33;
    localparam logic [CODE_BITS-1:0] CODE_JNEG = 7'h41;
    localparam logic [CODE_BITS-1:0] CODE_JZ   = 7'h42;
    localparam logic [CODE_BITS-1:0] CODE_SUBC = 7'h76;

    // Command to the serial multiply/divide unit
    typedef struct packed {
        logic start;
        logic is_div;
    } iter_cmd_t;

endpackage

>>> sv/acm_mem.sv
module acm_mem #(
    parameter int MEM_CELLS = 128,
    parameter int WORD_BITS = 32,
    parameter int AW        = 7
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr_en,
    input  logic [AW-1:0]        wr_addr,
    input  logic [WORD_BITS-1:0] wr_data,
    input  logic                 rd_en,
    input  logic [AW-1:0]        rd_addr,
    output logic [WORD_BITS-1:0] rd_data
);

    logic [WORD_BITS-1:0] mem_reg [MEM_CELLS];
    logic [MEM_CELLS-1:0] valid_reg;
    logic [WORD_BITS-1:0] rd_data_reg;
    logic                 rd_valid_reg;

    // Per-entry written flags; an unwritten cell reads as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
                valid_reg[wr_addr] <= 1'b1;
            if (rd_en)
                rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    // Storage array, one write and one registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem_reg[wr_addr] <= wr_data;
        if (rd_en)
            rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

>>> sv/acm_iter.sv
module acm_iter #(
    parameter int WORD_BITS = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  acm_pkg::iter_cmd_t   cmd,
    input  logic [WORD_BITS-1:0] opa,
    input  logic [WORD_BITS-1:0] opb,
    output logic                 done,
    output logic [WORD_BITS-1:0] result
);
    import acm_pkg::*;

    localparam int CW = $clog2(WORD_BITS + 1);

    logic                 busy_reg;
    logic                 done_reg;
    logic                 is_div_reg;
    logic [CW-1:0]        cnt_reg;
    // x: dividend/quotient or multiplier; y: divisor or multiplicand;
    // r: remainder or running product
    logic [WORD_BITS-1:0] x_reg;
    logic [WORD_BITS-1:0] y_reg;
    logic [WORD_BITS-1:0] r_reg;

    logic [WORD_BITS:0]   r_shift;
    logic [WORD_BITS:0]   r_diff;

    // One restoring-divide step
    assign r_shift = {r_reg, x_reg[WORD_BITS-1]};
    assign r_diff  = r_shift - {1'b0, y_reg};

    // Sequencing
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cmd.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(WORD_BITS);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: one bit per cycle
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            is_div_reg <= cmd.is_div;
            x_reg      <= opa;
            y_reg      <= opb;
            r_reg      <= '0;
        end
        else if (busy_reg)
        begin
            if (is_div_reg)
            begin
                if (!r_diff[WORD_BITS])
                begin
                    r_reg <= r_diff[WORD_BITS-1:0];
                    x_reg <= {x_reg[WORD_BITS-2:0], 1'b1};
                end
                else
                begin
                    r_reg <= r_shift[WORD_BITS-1:0];
                    x_reg <= {x_reg[WORD_BITS-2:0], 1'b0};
                end
            end
            else
            begin
                if (x_reg[0])
                    r_reg <= r_reg + y_reg;
                y_reg <= {y_reg[WORD_BITS-2:0], 1'b0};
                x_reg <= {1'b0, x_reg[WORD_BITS-1:1]};
            end
        end
    end

    assign done   = done_reg;
    assign result = is_div_reg ? x_reg : r_reg;

endmodule

>>> sv/accumulator_machine_alu.sv
// Accumulator machine ALU. Each request either stores write_word into a memory
// cell (op = 1) or executes one instruction (op = 0) against the word memory,
// the accumulator and the instruction counter, and gives exactly one result:
// accumulator, counter and a divide-by-zero fault flag. Requests are taken one
// at a time; in_stall is high from acceptance until the result is placed in
// the output register, which can be held by out_stall while the next request
// is accepted. A memory write or an operand outside memory goes from
// acceptance straight to the done state; ADD, SUB, JNEG, JZ, an unknown code,
// a divide by zero and a SUBC whose accumulator lies outside memory pass
// through the operand read; SUBC adds a second read (two reads of the single
// memory read port), and MUL and DIVIDE wait on the serial multiply/divide
// unit that retires one bit per cycle. The word memory comes out of reset
// reading zero in every cell at once; there is no clearing pass.
module accumulator_machine_alu #(
    parameter int MEM_CELLS = acm_pkg::MEM_CELLS_DEF,
    parameter int WORD_BITS = acm_pkg::WORD_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              op,
    input  logic [acm_pkg::CODE_BITS-1:0]     instr_code,
    input  logic [acm_pkg::ADDR_BITS-1:0]     operand_address,
    input  logic signed [acm_pkg::IO_WORD_BITS-1:0] write_word,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [acm_pkg::IO_WORD_BITS-1:0] acc_value,
    output logic [acm_pkg::ADDR_BITS-1:0]     counter_value,
    output logic                              fault
);
    import acm_pkg::*;

    localparam int AW = $clog2(MEM_CELLS);
    localparam logic [ADDR_BITS:0]   CELLS_LIM = (ADDR_BITS+1)'(MEM_CELLS);
    localparam logic [WORD_BITS-1:0] CELLS_W   = WORD_BITS'(MEM_CELLS);
    localparam logic [AW-1:0]        LAST_CELL = AW'(MEM_CELLS - 1);

    // Sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_OPND = 3'd1;
    localparam logic [2:0] S_SUBC = 3'd2;
    localparam logic [2:0] S_ITER = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0]           state_reg,   state_next;
    logic [WORD_BITS-1:0] acc_reg,     acc_next;
    logic [AW-1:0]        counter_reg, counter_next;
    logic                 fault_reg,   fault_next;
    logic [CODE_BITS-1:0] code_reg;
    logic [AW-1:0]        addr_reg;
    logic [WORD_BITS-1:0] m_reg;
    logic                 neg_reg;
    logic                 out_valid_reg, out_valid_next;
    logic [IO_WORD_BITS-1:0] acc_out_reg;
    logic [ADDR_BITS-1:0] cnt_out_reg;
    logic                 fault_out_reg;

    logic                 accept;
    logic                 in_range;
    logic                 out_load;
    logic [AW-1:0]        counter_inc;
    logic                 mem_wr_en;
    logic                 mem_rd_en;
    logic [AW-1:0]        mem_rd_addr;
    logic [WORD_BITS-1:0] mem_rd_data;
    logic [WORD_BITS-1:0] acc_mag;
    logic [WORD_BITS-1:0] m_mag;
    iter_cmd_t            iter_cmd;
    logic [WORD_BITS-1:0] iter_opa;
    logic [WORD_BITS-1:0] iter_opb;
    logic                 iter_done;
    logic [WORD_BITS-1:0] iter_result;

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != S_IDLE);
    assign in_range = ({1'b0, operand_address} < CELLS_LIM);
    assign out_load = (state_reg == S_DONE) && (!out_valid_reg || !out_stall);

    assign counter_inc = (counter_reg == LAST_CELL) ? '0 : counter_reg + 1'b1;

    // Magnitudes for the unsigned divider
    assign acc_mag = acc_reg[WORD_BITS-1] ? (~acc_reg + 1'b1) : acc_reg;
    assign m_mag   = mem_rd_data[WORD_BITS-1] ? (~mem_rd_data + 1'b1) : mem_rd_data;

    // Memory port control
    assign mem_wr_en   = accept && (op == OP_WRITE) && in_range;
    assign mem_rd_en   = (accept && (op == OP_EXEC) && in_range)
                         || ((state_reg == S_OPND) && (code_reg == CODE_SUBC));
    assign mem_rd_addr = (state_reg == S_IDLE) ? operand_address[AW-1:0]
                                               : acc_reg[AW-1:0];

    acm_mem #(
        .MEM_CELLS (MEM_CELLS),
        .WORD_BITS (WORD_BITS),
        .AW        (AW)
    ) u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (mem_wr_en),
        .wr_addr (operand_address[AW-1:0]),
        .wr_data (WORD_BITS'(write_word)),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    acm_iter #(
        .WORD_BITS (WORD_BITS)
    ) u_iter (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (iter_cmd),
        .opa    (iter_opa),
        .opb    (iter_opb),
        .done   (iter_done),
        .result (iter_result)
    );

    // Sequencer and architectural state update
    always_comb
    begin
        state_next     = state_reg;
        acc_next       = acc_reg;
        counter_next   = counter_reg;
        fault_next     = fault_reg;
        out_valid_next = out_valid_reg;
        iter_cmd       = '0;
        iter_opa       = acc_reg;
        iter_opb       = mem_rd_data;

        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    fault_next = 1'b0;
                    if ((op == OP_EXEC) && in_range)
                        state_next = S_OPND;
                    else
                        state_next = S_DONE;
                end
            end
            S_OPND:
            begin
                state_next = S_DONE;
                case (code_reg)
                    CODE_ADD:
                    begin
                        acc_next     = acc_reg + mem_rd_data;
                        counter_next = counter_inc;
                    end
                    CODE_SUB:
                    begin
                        acc_next     = acc_reg - mem_rd_data;
                        counter_next = counter_inc;
                    end
                    CODE_MUL:
                    begin
                        iter_cmd.start = 1'b1;
                        state_next     = S_ITER;
                    end
                    CODE_DIV:
                    begin
                        if (mem_rd_data == '0)
                        begin
                            fault_next   = 1'b1;
                            counter_next = counter_inc;
                        end
                        else
                        begin
                            iter_cmd.start  = 1'b1;
                            iter_cmd.is_div = 1'b1;
                            iter_opa        = acc_mag;
                            iter_opb        = m_mag;
                            state_next      = S_ITER;
                        end
                    end
                    CODE_JNEG:
                    begin
                        counter_next = acc_reg[WORD_BITS-1] ? addr_reg : counter_inc;
                    end
                    CODE_JZ:
                    begin
                        counter_next = (acc_reg == '0) ? addr_reg : counter_inc;
                    end
                    CODE_SUBC:
                    begin
                        if (acc_reg < CELLS_W)
                            state_next = S_SUBC;
                        else
                            counter_next = counter_inc;
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_SUBC:
            begin
                acc_next     = m_reg - mem_rd_data;
                counter_next = counter_inc;
                state_next   = S_DONE;
            end
            S_ITER:
            begin
                if (iter_done)
                begin
                    if ((code_reg == CODE_DIV) && neg_reg)
                        acc_next = ~iter_result + 1'b1;
                    else
                        acc_next = iter_result;
                    counter_next = counter_inc;
                    state_next   = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control and architectural registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            acc_reg       <= '0;
            counter_reg   <= '0;
            fault_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            acc_reg       <= acc_next;
            counter_reg   <= counter_next;
            fault_reg     <= fault_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Request capture, operand hold and output payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            code_reg <= instr_code;
            addr_reg <= operand_address[AW-1:0];
        end
        if (state_reg == S_OPND)
        begin
            m_reg   <= mem_rd_data;
            neg_reg <= acc_reg[WORD_BITS-1] ^ mem_rd_data[WORD_BITS-1];
        end
        if (out_load)
        begin
            acc_out_reg   <= IO_WORD_BITS'(acc_reg);
            cnt_out_reg   <= ADDR_BITS'(counter_reg);
            fault_out_reg <= fault_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign acc_value     = acc_out_reg;
    assign counter_value = cnt_out_reg;
    assign fault         = fault_out_reg;

`ifndef ASSERT_OFF
    // Only one request in flight
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> in_stall)
        else $error("request accepted while another is in flight");

    // The serial unit finishes only while the sequencer waits on it
    a_iter_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        iter_done |-> (state_reg == S_ITER))
        else $error("serial unit finished outside the wait state");

    // Instruction counter stays inside memory
    a_counter_range: assert property (@(posedge clk) disable iff (!rst_n)
        counter_reg <= LAST_CELL)
        else $error("instruction counter outside memory");

    // A fault leaves the accumulator unchanged
    a_fault_keeps_acc: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OPND) && (state_next == S_DONE) && fault_next
        |=> $stable(acc_reg))
        else $error("divide by zero changed the accumulator");
`endif

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    import acm_pkg::*;

    localparam int CELLS       = MEM_CELLS_DEF;
    localparam int MAX_IDLE    = 17;
    localparam int RAND_ITEMS  = 1350;
    localparam int CYCLE_LIMIT = 600000;
    localparam int TAIL_CYCLES = 60;

    // One request as the sender sees it, plus its pacing
    typedef struct {
        logic                    op;
        logic [CODE_BITS-1:0]    code;
        logic [ADDR_BITS-1:0]    addr;
        logic [IO_WORD_BITS-1:0] word;
        int                      gap;
        bit                      drain;
    } acm_request_t;

    // Machine state after one request
    typedef struct {
        logic [IO_WORD_BITS-1:0] acc;
        logic [ADDR_BITS-1:0]    counter;
        logic                    fault;
    } acm_outcome_t;

    logic clk;
    logic rst_n = 1'b0;

    logic                           in_valid = 1'b0;
    logic                           in_stall;
    logic                           op = OP_EXEC;
    logic [CODE_BITS-1:0]           instr_code = '0;
    logic [ADDR_BITS-1:0]           operand_address = '0;
    logic signed [IO_WORD_BITS-1:0] write_word = '0;
    logic                           out_valid;
    logic                           out_stall = 1'b0;
    logic signed [IO_WORD_BITS-1:0] acc_value;
    logic [ADDR_BITS-1:0]           counter_value;
    logic                           fault;

    acm_request_t pending_reqs[$];
    acm_outcome_t expected_states[$];
    acm_request_t on_bus;

    // Machine model state
    logic [IO_WORD_BITS-1:0] cell_mem [CELLS];
    logic [IO_WORD_BITS-1:0] acc_mdl;
    logic [ADDR_BITS-1:0]    pc_mdl;

    int  errors = 0;
    int  hold_cnt = 0;
    int  stall_left = 0;
    bit  recv_calm = 1'b0;
    bit  send_calm = 1'b0;
    longint cycle_cnt = 0;

    accumulator_machine_alu u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .op              (op),
        .instr_code      (instr_code),
        .operand_address (operand_address),
        .write_word      (write_word),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .acc_value       (acc_value),
        .counter_value   (counter_value),
        .fault           (fault)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Counter step, wrapping at the memory size
    function automatic logic [ADDR_BITS-1:0] next_pc(logic [ADDR_BITS-1:0] pc);
        return ADDR_BITS'((int'(pc) + 1) % CELLS);
    endfunction

    // Apply one request to the model state and return the resulting outputs
    function automatic acm_outcome_t run_instruction(acm_request_t rq);
        acm_outcome_t            res;
        logic [IO_WORD_BITS-1:0] m;
        logic [IO_WORD_BITS-1:0] a;
        logic [IO_WORD_BITS-1:0] ma;
        logic [IO_WORD_BITS-1:0] mm;
        logic [IO_WORD_BITS-1:0] q;
        res.fault = 1'b0;
        if (int'(rq.addr) < CELLS)
        begin
            if (rq.op == OP_WRITE)
                cell_mem[rq.addr] = rq.word;
            else
            begin
                m = cell_mem[rq.addr];
                a = acc_mdl;
                case (rq.code)
                    CODE_ADD:
                    begin
                        acc_mdl = a + m;
                        pc_mdl  = next_pc(pc_mdl);
                    end
                    CODE_SUB:
                    begin
                        acc_mdl = a - m;
                        pc_mdl  = next_pc(pc_mdl);
                    end
                    CODE_MUL:
                    begin
                        acc_mdl = a * m;
                        pc_mdl  = next_pc(pc_mdl);
                    end
                    CODE_DIV:
                    begin
                        // divide by zero keeps the accumulator
                        if (m == '0)
                            res.fault = 1'b1;
                        else
                        begin
                            ma = a[IO_WORD_BITS-1] ? -a : a;
                            mm = m[IO_WORD_BITS-1] ? -m : m;
                            q  = ma / mm;
                            if (a[IO_WORD_BITS-1] ^ m[IO_WORD_BITS-1])
                                q = -q;
                            acc_mdl = q;
                        end
                        pc_mdl = next_pc(pc_mdl);
                    end
                    CODE_JNEG:
                        pc_mdl = a[IO_WORD_BITS-1] ? rq.addr : next_pc(pc_mdl);
                    CODE_JZ:
                        pc_mdl = (a == '0) ? rq.addr : next_pc(pc_mdl);
                    CODE_SUBC:
                    begin
                        // accumulator doubles as the second address
                        if (a < CELLS)
                            acc_mdl = m - cell_mem[a[ADDR_BITS-1:0]];
                        pc_mdl = next_pc(pc_mdl);
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
        res.acc     = acc_mdl;
        res.counter = pc_mdl;
        return res;
    endfunction

    task automatic queue_req(logic rop, logic [CODE_BITS-1:0] rcode,
                             logic [ADDR_BITS-1:0] raddr, logic [IO_WORD_BITS-1:0] rword,
                             bit rdrain);
        acm_request_t rq;
        rq.op    = rop;
        rq.code  = rcode;
        rq.addr  = raddr;
        rq.word  = rword;
        rq.gap   = send_calm ? 0 : $urandom_range(0, MAX_IDLE);
        rq.drain = rdrain;
        pending_reqs.push_back(rq);
    endtask

    // Words biased toward small values and the extremes
    function automatic logic [IO_WORD_BITS-1:0] pick_word();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return IO_WORD_BITS'(int'($urandom_range(0, 16)) - 8);
            5:             return 32'h7FFF_FFFF;
            6:             return 32'h8000_0000;
            7:             return 32'hFFFF_FFFF;
            default:       return $urandom;
        endcase
    endfunction

    // Mostly low cells so that writes and reads meet
    function automatic logic [ADDR_BITS-1:0] pick_addr();
        if ($urandom_range(0, 3) != 0)
            return ADDR_BITS'($urandom_range(0, 15));
        return ADDR_BITS'($urandom_range(0, CELLS - 1));
    endfunction

    function automatic logic [CODE_BITS-1:0] pick_code();
        case ($urandom_range(0, 19))
            0, 1, 2:  return CODE_ADD;
            3, 4, 5:  return CODE_SUB;
            6, 7:     return CODE_MUL;
            8, 9, 10: return CODE_DIV;
            11, 12:   return CODE_JNEG;
            13, 14:   return CODE_JZ;
            15, 16, 17: return CODE_SUBC;
            default:  return CODE_BITS'($urandom_range(0, 127));
        endcase
    endfunction

    // Driver: presents pending requests, predicts each one on acceptance
    always @(posedge clk or negedge rst_n)
    begin : driver
        bit slot_free;
        if (!rst_n)
        begin
            in_valid        <= 1'b0;
            op              <= OP_EXEC;
            instr_code      <= '0;
            operand_address <= '0;
            write_word      <= '0;
            hold_cnt        <= 0;
        end
        else
        begin
            slot_free = !in_valid;
            if (in_valid && !in_stall)
            begin
                expected_states.push_back(run_instruction(on_bus));
                slot_free = 1'b1;
            end
            if (slot_free)
            begin
                if (pending_reqs.size() != 0 && hold_cnt >= pending_reqs[0].gap &&
                    !(pending_reqs[0].drain && expected_states.size() != 0))
                begin
                    on_bus          = pending_reqs.pop_front();
                    in_valid        <= 1'b1;
                    op              <= on_bus.op;
                    instr_code      <= on_bus.code;
                    operand_address <= on_bus.addr;
                    write_word      <= on_bus.word;
                    hold_cnt        <= 0;
                end
                else
                begin
                    in_valid <= 1'b0;
                    if (pending_reqs.size() != 0)
                        hold_cnt <= hold_cnt + 1;
                end
            end
        end
    end

    // Monitor: random back-pressure and field-by-field compare
    always @(posedge clk or negedge rst_n)
    begin : monitor
        acm_outcome_t want;
        int           nxt;
        if (!rst_n)
        begin
            out_stall  <= 1'b0;
            stall_left <= 0;
        end
        else
        begin
            nxt = stall_left;
            if (out_valid && !out_stall)
            begin
                if (expected_states.size() == 0)
                begin
                    $display("%0t: unexpected result acc %h counter %0d fault %b",
                             $time, acc_value, counter_value, fault);
                    errors++;
                end
                else
                begin
                    want = expected_states.pop_front();
                    if (acc_value !== want.acc)
                    begin
                        $display("%0t: acc_value expected %h actual %h",
                                 $time, want.acc, acc_value);
                        errors++;
                    end
                    if (counter_value !== want.counter)
                    begin
                        $display("%0t: counter_value expected %0d actual %0d",
                                 $time, want.counter, counter_value);
                        errors++;
                    end
                    if (fault !== want.fault)
                    begin
                        $display("%0t: fault expected %b actual %b",
                                 $time, want.fault, fault);
                        errors++;
                    end
                end
                if ($urandom_range(0, 39) == 0)
                    recv_calm = !recv_calm;
                nxt = recv_calm ? 0 : $urandom_range(0, MAX_IDLE);
            end
            if (nxt > 0)
            begin
                out_stall  <= 1'b1;
                stall_left <= nxt - 1;
            end
            else
            begin
                out_stall  <= 1'b0;
                stall_left <= 0;
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Stimulus and end of run
    initial
    begin : stimulus
        int  idx;
        int  count;
        logic [ADDR_BITS-1:0] a;
        for (idx = 0; idx < CELLS; idx++)
            cell_mem[idx] = '0;
        acc_mdl = '0;
        pc_mdl  = '0;

        // Directed: extremes, every code, overflow, fault, wrap, SUBC both ways
        queue_req(OP_WRITE, CODE_ADD, 7'd0,   32'h7FFF_FFFF, 1'b0);
        queue_req(OP_WRITE, 7'h7F,    7'd1,   32'h8000_0000, 1'b0);
        queue_req(OP_WRITE, 7'h00,    7'd2,   32'hFFFF_FFFF, 1'b0);
        queue_req(OP_WRITE, CODE_DIV, 7'd3,   32'h0000_0000, 1'b0);
        queue_req(OP_WRITE, CODE_SUB, 7'd127, 32'h0000_0001, 1'b0);
        queue_req(OP_WRITE, CODE_JZ,  7'd5,   32'h0000_0007, 1'b0);
        // wait for every write result before the first instruction
        queue_req(OP_EXEC,  CODE_ADD,  7'd0,   32'hFFFF_FFFF, 1'b1);
        queue_req(OP_EXEC,  CODE_ADD,  7'd127, 32'h0,         1'b0);
        queue_req(OP_EXEC,  CODE_JNEG, 7'd100, 32'h0,         1'b0);
        queue_req(OP_EXEC,  CODE_DIV,  7'd2,   32'h0,         1'b0);
        queue_req(OP_EXEC,  CODE_DIV,  7'd3,   32'h0,         1'b0);
        queue_req(OP_EXEC,  CODE_MUL,  7'd2,   32'h0,         1'b0);
        queue_req(OP_EXEC,  CODE_SUB,  7'd1,   32'h0,         1'b0);
        queue_req(OP_EXEC,  CODE_JNEG, 7'd9,   32'h0,         1'b0);
        queue_req(OP_EXEC,  CODE_JZ,   7'd127, 32'h0,         1'b0);
        queue_req(OP_EXEC,  CODE_ADD,  7'd5,   32'h0,         1'b0);
        queue_req(OP_EXEC,  CODE_SUBC, 7'd5,   32'h0,         1'b0);
        queue_req(OP_EXEC,  CODE_JZ,   7'd3,   32'h0,         1'b0);
        queue_req(OP_EXEC,  CODE_DIV,  7'd5,   32'h0,         1'b0);
        queue_req(OP_EXEC,  CODE_SUB,  7'd0,   32'h0,         1'b0);
        queue_req(OP_EXEC,  CODE_SUBC, 7'd0,   32'h0,         1'b0);
        queue_req(OP_EXEC,  7'h00,     7'd0,   32'h0,         1'b0);
        queue_req(OP_EXEC,  7'h7F,     7'd127, 32'h0,         1'b0);
        queue_req(OP_EXEC,  CODE_MUL,  7'd0,   32'h0,         1'b0);

        // Random: short well-formed sequences with random content, some noise
        count = 0;
        while (count < RAND_ITEMS)
        begin
            if (count % 40 == 0)
                send_calm = ($urandom_range(0, 3) == 0);
            a = pick_addr();
            case ($urandom_range(0, 9))
                0, 1, 2:
                begin
                    queue_req(OP_WRITE, CODE_BITS'($urandom_range(0, 127)), a, pick_word(),
                              count == 0 || $urandom_range(0, 299) == 0);
                    count += 1;
                end
                3, 4, 5, 6:
                begin
                    queue_req(OP_EXEC, pick_code(), a, $urandom,
                              $urandom_range(0, 299) == 0);
                    count += 1;
                end
                7:
                begin
                    // clear the accumulator, then branch on it
                    queue_req(OP_WRITE, CODE_MUL, a, '0, 1'b0);
                    queue_req(OP_EXEC, CODE_MUL, a, $urandom, 1'b0);
                    queue_req(OP_EXEC, ($urandom_range(0, 1) != 0) ? CODE_JZ : CODE_JNEG,
                              ADDR_BITS'($urandom_range(0, 127)), $urandom, 1'b0);
                    count += 3;
                end
                8:
                begin
                    // load a divisor and divide
                    queue_req(OP_WRITE, CODE_DIV, a, pick_word(), 1'b0);
                    queue_req(OP_EXEC, CODE_DIV, a, $urandom, 1'b0);
                    count += 2;
                end
                default:
                begin
                    // multiply the accumulator by a small word, then SUBC
                    queue_req(OP_WRITE, CODE_SUBC, a, IO_WORD_BITS'($urandom_range(0, 15)),
                              1'b0);
                    queue_req(OP_EXEC, CODE_MUL, a, $urandom, 1'b0);
                    queue_req(OP_EXEC, CODE_SUBC, pick_addr(), $urandom, 1'b0);
                    count += 3;
                end
            endcase
        end

        wait (rst_n === 1'b1);
        while (pending_reqs.size() != 0 || in_valid)
            @(posedge clk);
        while (expected_states.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (errors == 0 && expected_states.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Reset at the start, released on a falling edge away from the active edge
    initial
    begin
        rst_n = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

endmodule
